>>> sv/a7dd_pkg.sv
// Shared types and constants for the aperture-7 digit decomposition block.
`default_nettype none

package a7dd_pkg;

    localparam int LEVEL_W = 4;
    localparam int DIGIT_W = 3;
    localparam int BASE_W  = 23;
    localparam int LIMIT_W = 8;

    localparam logic [BASE_W-1:0]  BASE_MAX      = 23'd8388607;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 8'd2;
    localparam logic [DIGIT_W-1:0] DIGIT_INVALID = 3'd7;

    // level token that travels down the cell row
    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] level;
    } lnk_t;

    // one digit result leaving a cell
    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] level;
        logic [DIGIT_W-1:0] value;
    } dig_t;

    // summary result leaving the tail
    typedef struct packed {
        logic              valid;
        logic              oor;
        logic [BASE_W-1:0] bi;
        logic [BASE_W-1:0] bj;
        logic [BASE_W-1:0] bk;
    } sum_t;

endpackage

`default_nettype wire

>>> sv/a7dd_cell.sv
// One level cell: climbs one aperture-7 level and derives that level's digit.
`default_nettype none

module a7dd_cell
    import a7dd_pkg::*;
#(
    parameter int W = 24
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lnk_t                lnk_in,
    input  wire logic signed [W:0]   a_in,
    input  wire logic signed [W:0]   b_in,
    output lnk_t                     lnk_out,
    output logic signed [W:0]        a_out,
    output logic signed [W:0]        b_out,
    output dig_t                     dig_out
);

    localparam int AW  = W + 1;
    localparam int NXW = W + 4;
    localparam int NW  = W + 3;
    localparam int RW  = W + 4;
    localparam int S   = W + 6;
    localparam int DW  = W + 5;

    // exact floor(x / 7) for x below 2**NW as (x * RECIP) >> S
    localparam logic [63:0]     RECIP64 = ((64'd1 << S) + 64'd6) / 64'd7;
    localparam logic [RW-1:0]   RECIP   = RW'(RECIP64);
    // rounding bias plus an offset of 7 * 2**(W-1) that keeps the numerator positive
    localparam logic [63:0]     K64     = 64'd3 + 64'd7 * (64'd1 << (W - 1));
    localparam logic signed [NXW-1:0] K = NXW'(K64);
    localparam logic signed [DW-1:0]  D_ONE  = DW'(1);
    localparam logic signed [DW-1:0]  D_ZERO = '0;
    localparam logic signed [DW-1:0]  D_MONE = '1;

    logic                   ccw;
    logic                   active;
    logic signed [NXW-1:0]  ax, bx, a2, b2, a3, b3, n1, n2;
    logic [NW-1:0]          x1, x2;
    logic [NW+RW-1:0]       p1, p2;
    logic [W-1:0]           y1, y2;
    logic signed [AW-1:0]   q1, q2;

    lnk_t                   lnk_reg;
    lnk_t                   pend_reg;
    dig_t                   dig_reg;
    logic signed [AW-1:0]   a_reg, b_reg, ca_reg, cb_reg;

    logic                   pccw;
    logic signed [DW-1:0]   ca, cb, pa, pb, pa2, pb2, pa3, pb3;
    logic signed [DW-1:0]   dij, djk, dki;
    logic                   unit_ok;
    logic [DIGIT_W-1:0]     unit_code;

    // parent of the incoming coordinate
    always_comb
    begin
        ccw    = lnk_in.level[0];
        active = lnk_in.valid && (lnk_in.level != '0);
        ax     = NXW'(a_in);
        bx     = NXW'(b_in);
        a2     = ax <<< 1;
        b2     = bx <<< 1;
        a3     = a2 + ax;
        b3     = b2 + bx;
        n1     = ccw ? (a3 - bx + K) : (a2 + bx + K);
        n2     = ccw ? (ax + b2 + K) : (b3 - ax + K);
        x1     = n1[NW-1:0];
        x2     = n2[NW-1:0];
        p1     = x1 * RECIP;
        p2     = x2 * RECIP;
        y1     = p1[S +: W];
        y2     = p2[S +: W];
        // drop the offset: flip the top quotient bit, then sign-extend
        q1     = {~y1[W-1], ~y1[W-1], y1[W-2:0]};
        q2     = {~y2[W-1], ~y2[W-1], y2[W-2:0]};
    end

    // pairwise differences of child minus re-expanded centre
    always_comb
    begin
        pccw = pend_reg.level[0];
        ca   = DW'(ca_reg);
        cb   = DW'(cb_reg);
        pa   = DW'(a_reg);
        pb   = DW'(b_reg);
        pa2  = pa <<< 1;
        pb2  = pb <<< 1;
        pa3  = pa2 + pa;
        pb3  = pb2 + pb;
        dij  = pccw ? (ca - cb - pa3 + pb2) : (ca - cb - pa2 + pb3);
        djk  = pccw ? (cb - pb3 + pa)       : (cb - pa - pb2);
        dki  = pccw ? (pa2 + pb - ca)       : (pa3 - pb - ca);
        unit_ok = (dij == D_ONE || dij == D_ZERO || dij == D_MONE)
               && (djk == D_ONE || djk == D_ZERO || djk == D_MONE)
               && (dki == D_ONE || dki == D_ZERO || dki == D_MONE);
        unit_code = {(dij == D_ONE) || (dki == D_MONE),
                     (djk == D_ONE) || (dij == D_MONE),
                     (dki == D_ONE) || (djk == D_MONE)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lnk_reg  <= '0;
            pend_reg <= '0;
            dig_reg  <= '0;
        end
        else
        begin
            lnk_reg.valid  <= lnk_in.valid;
            lnk_reg.level  <= active ? (lnk_in.level - LEVEL_W'(1)) : lnk_in.level;
            pend_reg.valid <= active;
            pend_reg.level <= lnk_in.level;
            dig_reg.valid  <= pend_reg.valid;
            dig_reg.level  <= pend_reg.level;
            dig_reg.value  <= unit_ok ? unit_code : DIGIT_INVALID;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= active ? q1 : a_in;
        b_reg  <= active ? q2 : b_in;
        ca_reg <= a_in;
        cb_reg <= b_in;
    end

    assign lnk_out = lnk_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign dig_out = dig_reg;

endmodule

`default_nettype wire

>>> sv/a7dd_summary.sv
// Tail stage: normalizes the level-0 coordinate, saturates it and checks the limit.
`default_nettype none

module a7dd_summary
    import a7dd_pkg::*;
#(
    parameter int W = 24
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic signed [W:0]  a_in,
    input  wire logic signed [W:0]  b_in,
    input  wire logic [LIMIT_W-1:0] limit,
    output sum_t                    sum_out
);

    localparam int AW   = W + 1;
    localparam int CMPW = ((W > BASE_W) ? W : BASE_W) + 1;

    logic signed [AW-1:0] mab, mn, di, dj, dk;
    logic                 s1_valid_reg;
    logic [W-1:0]         bi_reg, bj_reg, bk_reg;
    logic [CMPW-1:0]      ei, ej, ek, lim_x, max_x;
    sum_t                 sum_reg;

    // coordinate is (a, b, 0); subtract its minimum component
    always_comb
    begin
        mab = (a_in < b_in) ? a_in : b_in;
        mn  = mab[AW-1] ? mab : '0;
        di  = a_in - mn;
        dj  = b_in - mn;
        dk  = -mn;
    end

    always_comb
    begin
        ei    = CMPW'(bi_reg);
        ej    = CMPW'(bj_reg);
        ek    = CMPW'(bk_reg);
        lim_x = CMPW'(limit);
        max_x = CMPW'(BASE_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            sum_reg.valid <= s1_valid_reg;
            sum_reg.oor   <= (ei > lim_x) || (ej > lim_x) || (ek > lim_x);
            sum_reg.bi    <= (ei > max_x) ? BASE_MAX : ei[BASE_W-1:0];
            sum_reg.bj    <= (ej > max_x) ? BASE_MAX : ej[BASE_W-1:0];
            sum_reg.bk    <= (ek > max_x) ? BASE_MAX : ek[BASE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        bi_reg <= di[W-1:0];
        bj_reg <= dj[W-1:0];
        bk_reg <= dk[W-1:0];
    end

    assign sum_out = sum_reg;

endmodule

`default_nettype wire

>>> sv/aperture7_ijk_digit_decompose.sv
// Top level: entry register, row of level cells, summary tail and result register.
// Order: the digit of level r comes from cell (R - r), so digits leave in falling
//   level order, and the summary item leaves after the last of them.
// Issue: a new item is taken only while busy is low, that is once the summary item
//   of the last one reaches the result register; the row holds MAX_RESOLUTION cells
//   plus two tail stages. Reset: rst_n clears all control state and loads the limit
//   register with 2; the receiver cannot stall, so each result item is shown for exactly one cycle.
`default_nettype none

module aperture7_ijk_digit_decompose
    import a7dd_pkg::*;
#(
    parameter int MAX_RESOLUTION = 15,
    parameter int COORD_WIDTH    = 24
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] coord_i,
    input  wire logic signed [COORD_WIDTH-1:0] coord_j,
    input  wire logic signed [COORD_WIDTH-1:0] coord_k,
    input  wire logic [LEVEL_W-1:0]            resolution,
    input  wire logic                          cfg_we,
    input  wire logic [LIMIT_W-1:0]            cfg_wdata,
    output logic                               result_valid,
    output logic [LEVEL_W-1:0]                 digit_level,
    output logic [DIGIT_W-1:0]                 digit_value,
    output logic [BASE_W-1:0]                  base_i,
    output logic [BASE_W-1:0]                  base_j,
    output logic [BASE_W-1:0]                  base_k,
    output logic                               out_of_range,
    output logic                               is_last
);

    localparam int W  = COORD_WIDTH;
    localparam int AW = W + 1;
    localparam int NC = MAX_RESOLUTION;
    localparam logic [LEVEL_W-1:0] RES_MAX = LEVEL_W'(MAX_RESOLUTION);

    logic                 accept;
    logic                 busy_reg, busy_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [LEVEL_W-1:0]   res_clamp;

    // the row of cells: position 0 is fed by the entry register
    lnk_t                 lnk_w [0:NC];
    logic signed [AW-1:0] a_w   [0:NC];
    logic signed [AW-1:0] b_w   [0:NC];
    dig_t                 dig_w [0:NC-1];
    sum_t                 sum_w;

    logic [NC-1:0]        dig_hits;
    logic                 dig_any;
    logic [LEVEL_W-1:0]   dig_lvl;
    logic [DIGIT_W-1:0]   dig_val;

    lnk_t                 entry_reg;
    logic signed [AW-1:0] ea_reg, eb_reg;

    logic                 result_valid_reg;
    logic [LEVEL_W-1:0]   digit_level_reg;
    logic [DIGIT_W-1:0]   digit_value_reg;
    logic [BASE_W-1:0]    base_i_reg, base_j_reg, base_k_reg;
    logic                 out_of_range_reg, is_last_reg;

    assign accept    = start && !busy_reg;
    assign res_clamp = (resolution > RES_MAX) ? RES_MAX : resolution;

    // hold busy from acceptance until the summary item is loaded for output
    always_comb
    begin
        busy_next = busy_reg;
        if (sum_w.valid)
        begin
            busy_next = 1'b0;
        end
        else if (accept)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            limit_reg        <= LIMIT_RESET;
            entry_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg         <= busy_next;
            entry_reg.valid  <= accept;
            entry_reg.level  <= res_clamp;
            result_valid_reg <= dig_any || sum_w.valid;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // the climb only needs i-k and j-k: any shift along (1,1,1) drops out
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ea_reg <= {coord_i[W-1], coord_i} - {coord_k[W-1], coord_k};
            eb_reg <= {coord_j[W-1], coord_j} - {coord_k[W-1], coord_k};
        end
    end

    assign lnk_w[0] = entry_reg;
    assign a_w[0]   = ea_reg;
    assign b_w[0]   = eb_reg;

    // each cell takes the token, climbs if its level is nonzero, and hands on
    for (genvar p = 0; p < NC; p++)
    begin : g_cell
        a7dd_cell #(
            .W (W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .lnk_in  (lnk_w[p]),
            .a_in    (a_w[p]),
            .b_in    (b_w[p]),
            .lnk_out (lnk_w[p+1]),
            .a_out   (a_w[p+1]),
            .b_out   (b_w[p+1]),
            .dig_out (dig_w[p])
        );
    end

    a7dd_summary #(
        .W (W)
    ) u_summary (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (lnk_w[NC].valid),
        .a_in     (a_w[NC]),
        .b_in     (b_w[NC]),
        .limit    (limit_reg),
        .sum_out  (sum_w)
    );

    // at most one cell holds a digit in any cycle, so merge them with a masked OR
    always_comb
    begin
        dig_lvl = '0;
        dig_val = '0;
        for (int p = 0; p < NC; p++)
        begin
            dig_hits[p] = dig_w[p].valid;
            dig_lvl     = dig_lvl | (dig_w[p].level & {LEVEL_W{dig_w[p].valid}});
            dig_val     = dig_val | (dig_w[p].value & {DIGIT_W{dig_w[p].valid}});
        end
        dig_any = |dig_hits;
    end

    // result register: summary fields on the last item, zeros elsewhere
    always_ff @(posedge clk)
    begin
        if (sum_w.valid)
        begin
            digit_level_reg  <= '0;
            digit_value_reg  <= '0;
            base_i_reg       <= sum_w.bi;
            base_j_reg       <= sum_w.bj;
            base_k_reg       <= sum_w.bk;
            out_of_range_reg <= sum_w.oor;
            is_last_reg      <= 1'b1;
        end
        else
        begin
            digit_level_reg  <= dig_lvl;
            digit_value_reg  <= dig_val;
            base_i_reg       <= '0;
            base_j_reg       <= '0;
            base_k_reg       <= '0;
            out_of_range_reg <= 1'b0;
            is_last_reg      <= 1'b0;
        end
    end

    assign busy         = busy_reg;
    assign result_valid = result_valid_reg;
    assign digit_level  = digit_level_reg;
    assign digit_value  = digit_value_reg;
    assign base_i       = base_i_reg;
    assign base_j       = base_j_reg;
    assign base_k       = base_k_reg;
    assign out_of_range = out_of_range_reg;
    assign is_last      = is_last_reg;

    a_dig_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(dig_hits))
        else $error("two cells emit a digit in the same cycle");

    a_dig_vs_sum: assert property (@(posedge clk) disable iff (!rst_n)
        !(dig_any && sum_w.valid))
        else $error("digit and summary collide at the result register");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_last) |-> !busy)
        else $error("busy still set when the summary item is shown");

    a_digit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !is_last) |-> busy)
        else $error("digit item shown while the block is idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

endmodule

`default_nettype wire
